>>> src/pwrcs_pkg.sv
// ----------------------------------------------------------------------------
// pwrcs_pkg
// Shared types and constants for the pulse-width remote code sender.
// ----------------------------------------------------------------------------
package pwrcs_pkg;

   localparam int DATA_BITS  = 16;
   localparam int COPIES     = 4;
   localparam int TICK_WIDTH = 16;

   localparam int CFG_W      = 16;
   localparam int CODE_W     = 16;
   localparam int CMP_W      = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
   localparam int BIT_IDX_W  = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
   localparam int CODE_EXT_W = (DATA_BITS > CODE_W) ? DATA_BITS : CODE_W;
   localparam int COPY_W     = 4;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_PRESS   = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_GAP   = 3'd0,
      CSR_SHORT_GAP  = 3'd1,
      CSR_PREAMBLE   = 3'd2,
      CSR_PRE_ENABLE = 3'd3,
      CSR_ON_CODE    = 3'd4,
      CSR_OFF_CODE   = 3'd5
   } csr_idx_type;

   typedef enum logic [6:0] {
      PH_IDLE          = 7'b0000001,
      PH_LONG_GAP      = 7'b0000010,
      PH_PREAMBLE      = 7'b0000100,
      PH_SHORT_GAP     = 7'b0001000,
      PH_DATA          = 7'b0010000,
      PH_SHORT_GAP_EXT = 7'b0100000,
      PH_LONG_GAP_EXT  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0]  long_gap_ticks;
      logic [CFG_W-1:0]  short_gap_ticks;
      logic [CFG_W-1:0]  preamble_ticks;
      logic              preamble_enable;
      logic [CODE_W-1:0] on_code;
      logic [CODE_W-1:0] off_code;
   } cfg_type;

   typedef struct packed {
      logic data_pin;
      logic sending;
      logic indicator;
   } rsp_type;

endpackage

>>> src/pwrcs_core.sv
// ----------------------------------------------------------------------------
// pwrcs_core
// Frame sequencer: phase, counters and pin state, one item per step.
// ----------------------------------------------------------------------------
module pwrcs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [1:0]          operation,
   input  logic                button,
   input  pwrcs_pkg::cfg_type  cfg,
   output pwrcs_pkg::rsp_type  rsp_next
);
   import pwrcs_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in, tick_inc;
   logic [BIT_IDX_W-1:0]  bit_idx_ff, bit_idx_in;
   logic [1:0]            high_left_ff, high_left_in;
   logic [COPY_W-1:0]     copies_ff, copies_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic                  pin_ff, pin_in;
   logic                  run_ff, run_in;
   logic                  ind_ff, ind_in;

   logic [CODE_EXT_W-1:0] code_shift;
   logic                  code_bit;
   logic                  hit_long, hit_short, hit_pre;
   logic                  more_copies;

   assign tick_inc    = tick_ff + TICK_WIDTH'(1);
   assign code_shift  = CODE_EXT_W'(code_ff) >> bit_idx_ff;
   assign code_bit    = code_shift[0];
   assign hit_long    = CMP_W'(tick_inc) == CMP_W'(cfg.long_gap_ticks);
   assign hit_short   = CMP_W'(tick_inc) == CMP_W'(cfg.short_gap_ticks);
   assign hit_pre     = CMP_W'(tick_inc) == CMP_W'(cfg.preamble_ticks);
   assign more_copies = ({1'b0, copies_ff} + (COPY_W+1)'(1)) < (COPY_W+1)'(COPIES);

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_idx_in   = bit_idx_ff;
      high_left_in = high_left_ff;
      copies_in    = copies_ff;
      code_in      = code_ff;
      pin_in       = pin_ff;
      run_in       = run_ff;
      ind_in       = ind_ff;
      unique case (operation)
         OP_TICK: begin
            if (run_ff) begin
               tick_in = tick_inc;
               unique case (phase_ff)
                  PH_LONG_GAP: begin
                     if (hit_long) begin
                        copies_in = '0;
                        tick_in   = '0;
                        if (cfg.preamble_enable) begin
                           phase_in = PH_PREAMBLE;
                        end else begin
                           phase_in   = PH_DATA;
                           bit_idx_in = BIT_IDX_W'(DATA_BITS - 1);
                        end
                     end
                  end
                  PH_PREAMBLE: begin
                     if (hit_pre) begin
                        phase_in = PH_SHORT_GAP;
                        tick_in  = '0;
                     end else begin
                        pin_in = tick_inc[0];
                     end
                  end
                  PH_SHORT_GAP: begin
                     if (hit_short) begin
                        phase_in   = PH_DATA;
                        tick_in    = '0;
                        bit_idx_in = BIT_IDX_W'(DATA_BITS - 1);
                     end
                  end
                  PH_DATA: begin
                     if (tick_inc == TICK_WIDTH'(1)) begin
                        pin_in       = 1'b1;
                        high_left_in = code_bit ? 2'd3 : 2'd1;
                     end else if (tick_inc == TICK_WIDTH'(4)) begin
                        tick_in = '0;
                        pin_in  = 1'b0;
                        if (bit_idx_ff == '0) begin
                           if (more_copies) begin
                              phase_in  = PH_SHORT_GAP_EXT;
                              copies_in = copies_ff + COPY_W'(1);
                           end else begin
                              phase_in = PH_LONG_GAP_EXT;
                           end
                        end else begin
                           bit_idx_in = bit_idx_ff - BIT_IDX_W'(1);
                        end
                     end else if (high_left_ff != 2'd0) begin
                        high_left_in = high_left_ff - 2'd1;
                        if (high_left_ff == 2'd1) begin
                           pin_in = 1'b0;
                        end
                     end
                  end
                  PH_SHORT_GAP_EXT: begin
                     tick_in  = '0;
                     phase_in = PH_SHORT_GAP;
                  end
                  PH_LONG_GAP_EXT: begin
                     tick_in  = '0;
                     phase_in = PH_LONG_GAP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_PRESS: begin
            tick_in  = '0;
            phase_in = PH_LONG_GAP;
            code_in  = button ? cfg.off_code : cfg.on_code;
            ind_in   = 1'b1;
            run_in   = 1'b1;
         end
         OP_RELEASE: begin
            ind_in = 1'b0;
            if (run_ff) begin
               run_in = 1'b0;
               pin_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_next.data_pin  = pin_in;
   assign rsp_next.sending   = run_in;
   assign rsp_next.indicator = ind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_idx_ff   <= '0;
         high_left_ff <= '0;
         copies_ff    <= '0;
         code_ff      <= '0;
         pin_ff       <= 1'b0;
         run_ff       <= 1'b0;
         ind_ff       <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_idx_ff   <= bit_idx_in;
         high_left_ff <= high_left_in;
         copies_ff    <= copies_in;
         code_ff      <= code_in;
         pin_ff       <= pin_in;
         run_ff       <= run_in;
         ind_ff       <= ind_in;
      end
   end

endmodule

>>> src/pulse_width_remote_code_sender.sv
// ----------------------------------------------------------------------------
// pulse_width_remote_code_sender
// Keying sender for a radio remote, stepped by tick, press and release items.
//
//   port group   direction  handshake        payload
//   req_*        in         valid / stall    operation, button
//   rsp_*        out        valid / stall    data_pin, sending, indicator
//   csr_*        in         valid / ready    index, data (16 bit)
//
// One item per cycle sustained while rsp_stall does not hold the result register.
// The item sits in an input register, then the sequencer updates its state
// and loads the result register in the same cycle.
// Synchronous active-high reset restores state, valid flags and configuration defaults.
// rsp_stall holds the result register and, through it, the input register.
// ----------------------------------------------------------------------------
module pulse_width_remote_code_sender (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic                                 req_button,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_data_pin,
   output logic                                 rsp_sending,
   output logic                                 rsp_indicator,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pwrcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pwrcs_pkg::CFG_W-1:0]          csr_data
);
   import pwrcs_pkg::*;

   cfg_type    cfg_ff;
   logic       in_vld_ff;
   logic [1:0] in_op_ff;
   logic       in_btn_ff;
   logic       out_vld_ff;
   rsp_type    out_ff;
   rsp_type    rsp_next;
   logic       out_blocked;
   logic       step;

   assign out_blocked = out_vld_ff & rsp_stall;
   assign req_stall   = in_vld_ff & out_blocked;
   assign step        = in_vld_ff & ~out_blocked;
   assign csr_ready   = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_gap_ticks  <= CFG_W'(32);
         cfg_ff.short_gap_ticks <= CFG_W'(8);
         cfg_ff.preamble_ticks  <= CFG_W'(24);
         cfg_ff.preamble_enable <= 1'b1;
         cfg_ff.on_code         <= CODE_W'(16'h6821);
         cfg_ff.off_code        <= CODE_W'(16'h6811);
      end else if (csr_valid & csr_ready) begin
         unique case (csr_index)
            CSR_LONG_GAP:   cfg_ff.long_gap_ticks  <= csr_data;
            CSR_SHORT_GAP:  cfg_ff.short_gap_ticks <= csr_data;
            CSR_PREAMBLE:   cfg_ff.preamble_ticks  <= csr_data;
            CSR_PRE_ENABLE: cfg_ff.preamble_enable <= csr_data[0];
            CSR_ON_CODE:    cfg_ff.on_code         <= csr_data;
            CSR_OFF_CODE:   cfg_ff.off_code        <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_op_ff  <= req_operation;
         in_btn_ff <= req_button;
      end
   end

   pwrcs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .operation (in_op_ff),
      .button    (in_btn_ff),
      .cfg       (cfg_ff),
      .rsp_next  (rsp_next)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!out_blocked) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_data_pin  = out_ff.data_pin;
   assign rsp_sending   = out_ff.sending;
   assign rsp_indicator = out_ff.indicator;

endmodule
